### sv/websocket_frame_receiver_macros.svh
// assertion macros shared by the websocket frame receiver modules
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define WSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is applied
`define WSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/wsr_pkg.sv
// shared types and constants of the websocket frame receiver
`default_nettype none

package wsr_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// result kinds
	localparam logic [2:0] KIND_DATA  = 3'd0;
	localparam logic [2:0] KIND_EMPTY = 3'd1;
	localparam logic [2:0] KIND_PONG  = 3'd2;
	localparam logic [2:0] KIND_CLOSE = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	// opcodes with special handling
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	// seven-bit length codes that announce an extended length
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// extended length byte counts, stored minus one
	localparam logic [2:0] EXT16_LEFT = 3'd1;
	localparam logic [2:0] EXT64_LEFT = 3'd7;

	// index of the last mask key byte
	localparam logic [2:0] MASK_LAST = 3'd3;

	// command queue between parser and output stage
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// one queued command; pair marks a pong header that expands to two beats
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       last;
		logic       pair;
	} cmd_t;

endpackage

`default_nettype wire

### sv/wsr_front.sv
// frame parser: walks the header, length and mask key, unmasks payload
`default_nettype none

module wsr_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 accept,
	input  wire  [7:0]          rx_byte,
	output logic                push,
	output wsr_pkg::cmd_t       cmd
);
	import wsr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  hdr_q, hdr_d;
	logic [63:0] len_q, len_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] key_q, key_d;
	logic        stop_q, stop_d;

	logic [3:0]  op;
	logic [7:0]  key_byte;
	logic [7:0]  plain;
	logic        len_zero;
	logic        len_one;
	logic        is_ctl;

	assign op       = hdr_q[3:0];
	assign len_zero = (len_q == 64'd0);
	assign len_one  = (len_q == 64'd1);
	assign is_ctl   = op inside {OP_CLOSE, OP_PING};

	// mask key byte for this payload index, first key byte on top
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end
	assign plain = rx_byte ^ key_byte;

	// next state and context registers
	always_comb begin
		phase_d = phase_q;
		hdr_d   = hdr_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		key_d   = key_q;
		stop_d  = stop_q;
		if (accept && !stop_q) begin
			case (phase_q)
				PH_HDR0: begin
					hdr_d   = rx_byte;
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					if (!rx_byte[7]) begin
						stop_d = 1'b1;
					end else if (rx_byte[6:0] == LEN7_EXT16) begin
						len_d   = 64'd0;
						cnt_d   = EXT16_LEFT;
						phase_d = PH_EXTLEN;
					end else if (rx_byte[6:0] == LEN7_EXT64) begin
						len_d   = 64'd0;
						cnt_d   = EXT64_LEFT;
						phase_d = PH_EXTLEN;
					end else begin
						len_d   = {57'd0, rx_byte[6:0]};
						cnt_d   = 3'd0;
						phase_d = PH_MASK;
					end
				end
				PH_EXTLEN: begin
					len_d = {len_q[55:0], rx_byte};
					if (cnt_q == 3'd0) begin
						phase_d = PH_MASK;
					end else begin
						cnt_d = cnt_q - 3'd1;
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], rx_byte};
					if (cnt_q == MASK_LAST) begin
						cnt_d = 3'd0;
						if (!len_zero) begin
							phase_d = PH_PAYLOAD;
						end else if (op == OP_CLOSE) begin
							stop_d = 1'b1;
						end else begin
							phase_d = PH_HDR0;
						end
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
				PH_PAYLOAD: begin
					len_d = len_q - 64'd1;
					cnt_d = cnt_q + 3'd1;
					if (len_one) begin
						cnt_d = 3'd0;
						if (op == OP_CLOSE) begin
							stop_d = 1'b1;
						end else begin
							phase_d = PH_HDR0;
						end
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
		end
	end

	// command to the queue, at most one per byte
	always_comb begin
		push       = 1'b0;
		cmd.kind   = KIND_DATA;
		cmd.data   = 8'd0;
		cmd.opcode = op;
		cmd.last   = 1'b0;
		cmd.pair   = 1'b0;
		if (accept && !stop_q) begin
			case (phase_q)
				PH_HDR1: begin
					if (!rx_byte[7]) begin
						push     = 1'b1;
						cmd.kind = KIND_ERROR;
					end
				end
				PH_MASK: begin
					if (cnt_q == MASK_LAST && len_zero) begin
						push = 1'b1;
						if (op == OP_CLOSE) begin
							cmd.kind = KIND_CLOSE;
						end else if (op == OP_PING) begin
							cmd.kind = KIND_PONG;
							cmd.data = hdr_q + 8'd1;
							cmd.pair = 1'b1;
						end else begin
							cmd.kind = KIND_EMPTY;
						end
					end
				end
				PH_PAYLOAD: begin
					if (!is_ctl) begin
						push     = 1'b1;
						cmd.data = plain;
						cmd.last = len_one;
					end else if (len_one) begin
						push = 1'b1;
						if (op == OP_CLOSE) begin
							cmd.kind = KIND_CLOSE;
						end else begin
							cmd.kind = KIND_PONG;
							cmd.data = hdr_q + 8'd1;
							cmd.pair = 1'b1;
						end
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			hdr_q   <= 8'd0;
			len_q   <= 64'd0;
			cnt_q   <= 3'd0;
			key_q   <= 32'd0;
			stop_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			key_q   <= key_d;
			stop_q  <= stop_d;
		end
	end

endmodule

`default_nettype wire

### sv/wsr_fifo.sv
// short command queue between the parser and the output stage
`default_nettype none
`include "websocket_frame_receiver_macros.svh"

module wsr_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wsr_pkg::cmd_t       wr_cmd,
	input  wire                 pop,
	output wsr_pkg::cmd_t       rd_cmd,
	output logic                not_empty,
	output logic                full
);
	import wsr_pkg::*;

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	assign not_empty = (count_q != FIFO_CW'(0));
	assign full      = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign rd_cmd    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CW'(1);
				2'b01:   count_q <= count_q - FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`WSR_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, not_empty, "pop from empty queue")
	`WSR_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full || pop, "push into full queue")

endmodule

`default_nettype wire

### sv/wsr_back.sv
// output stage: takes queued commands and drives result beats
`default_nettype none
`include "websocket_frame_receiver_macros.svh"

module wsr_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wsr_pkg::cmd_t       head,
	input  wire                 not_empty,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [2:0]          kind,
	output logic [7:0]          data,
	output logic [3:0]          opcode,
	output logic                last
);
	import wsr_pkg::*;

	logic       valid_q;
	logic       pend_q;
	logic [2:0] kind_q;
	logic [7:0] data_q;
	logic [3:0] opcode_q;
	logic       last_q;
	logic       take;
	logic       free;

	assign take = valid_q && !out_stall;
	assign free = !valid_q || take;
	assign pop  = free && !pend_q && not_empty;

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign data      = data_q;
	assign opcode    = opcode_q;
	assign last      = last_q;

	// control: valid beat and pending second pong byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= not_empty;
				pend_q  <= not_empty && head.pair;
			end
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (free) begin
			if (pend_q) begin
				kind_q <= KIND_PONG;
				data_q <= 8'd0;
				last_q <= 1'b1;
			end else if (not_empty) begin
				kind_q   <= head.kind;
				data_q   <= head.data;
				opcode_q <= head.opcode;
				last_q   <= head.last;
			end
		end
	end

	`WSR_ASSERT_IMP(a_pend_shape, clk, arst_n, pend_q, valid_q && kind_q == KIND_PONG && !last_q, "pending pong without first byte shown")
	`WSR_ASSERT_NXT(a_pong_pair, clk, arst_n, take && kind_q == KIND_PONG && !last_q, valid_q && kind_q == KIND_PONG && last_q, "second pong byte missing")

endmodule

`default_nettype wire

### sv/websocket_frame_receiver.sv
// top level of the websocket frame receiver
`default_nettype none

// Server-side WebSocket deframer. One received byte is taken per cycle on
// the input channel (rx_byte) unless stalled; the parser classifies it at once
// and queues at most one command per byte in a four-entry queue, and the
// output stage turns each command into one result beat per cycle unless
// stalled, or two beats for a pong header (header byte plus one, then zero
// with last set). Sustained rate is one byte per cycle; a ping ends with two
// output beats from one byte, and in_stall rises only when the queue is full,
// set by how fast the output side takes beats. Results are registered at the
// output. After a close event or an unmasked frame error, bytes are still
// taken but dropped until reset. Payload lengths up to 64 bits are honoured.
module websocket_frame_receiver (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  rx_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  data,
	output logic [3:0]  opcode,
	output logic        last
);
	import wsr_pkg::*;

	logic  accept;
	logic  push;
	logic  pop;
	logic  not_empty;
	logic  full;
	cmd_t  wr_cmd;
	cmd_t  head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	// parser
	wsr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.push    (push),
		.cmd     (wr_cmd)
	);

	// command queue
	wsr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.pop       (pop),
		.rd_cmd    (head),
		.not_empty (not_empty),
		.full      (full)
	);

	// output stage
	wsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data      (data),
		.opcode    (opcode),
		.last      (last)
	);

endmodule

`default_nettype wire
